/* rtl/dqrm_pkg.sv */
// Shared types and constants for the deque with remove-by-value.
// Used by dqrm_ctrl, dqrm_dp and the top level deque_with_remove_matching.
package dqrm_pkg;

    typedef enum logic [1:0] {
        FUNC_PUSH_BACK  = 2'd0,
        FUNC_PUSH_FRONT = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_REMOVE     = 2'd3
    } func_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int IdPortW  = 16;
    localparam int CntPortW = 5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic push;
        logic pop_rd;
        logic pop_done;
        logic scan_init;
        logic scan_step;
        logic fail_done;
    } dq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        func_t func;
        logic  full;
        logic  empty;
        logic  scan_last;
        logic  slot_free;
    } dq_sts_t;

endpackage

/* rtl/dqrm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dqrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/dqrm_ctrl.sv */
// Controller state machine for the deque: sequences push, pop and the remove scan.
// Depends on dqrm_pkg for the command and status structs.
module dqrm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  dqrm_pkg::dq_sts_t sts,
    output dqrm_pkg::dq_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POP  = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.func)
                    dqrm_pkg::FUNC_PUSH_BACK, dqrm_pkg::FUNC_PUSH_FRONT:
                    begin
                        if (sts.slot_free)
                        begin
                            cmd.fail_done = sts.full;
                            cmd.push      = !sts.full;
                            state_next    = S_IDLE;
                        end
                    end
                    dqrm_pkg::FUNC_POP_FRONT:
                    begin
                        if (!sts.empty)
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_POP;
                        end
                        else if (sts.slot_free)
                        begin
                            cmd.fail_done = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (!sts.empty)
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                        else if (sts.slot_free)
                        begin
                            cmd.fail_done = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP:
            begin
                if (sts.slot_free)
                begin
                    cmd.pop_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // hold the final step until the result register can take it
                if (!sts.scan_last || sts.slot_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/dqrm_dp.sv */
// Datapath for the deque: front/count registers, entry RAM, scan counters, result register.
// Depends on dqrm_pkg and dqrm_ram.
module dqrm_dp #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [1:0]                            func,
    input  logic [dqrm_pkg::IdPortW-1:0]          tray_id,
    input  logic                                  rsp_stall,
    input  dqrm_pkg::dq_cmd_t                     cmd,
    output dqrm_pkg::dq_sts_t                     sts,
    output logic                                  rsp_valid,
    output logic [dqrm_pkg::IdPortW-1:0]          tray_out,
    output logic [1:0]                            status,
    output logic [dqrm_pkg::CntPortW-1:0]         removed_count,
    output logic [dqrm_pkg::CntPortW-1:0]         count_after
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dqrm_pkg::func_t              func_reg;
    logic [ID_BITS-1:0]           id_reg;
    logic [AW-1:0]                front_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                k_reg;
    logic [CW-1:0]                kept_reg;
    logic [CW-1:0]                removed_reg;

    logic                         rsp_valid_reg;
    logic [dqrm_pkg::IdPortW-1:0] rsp_tray_reg;
    logic [1:0]                   rsp_status_reg;
    logic [dqrm_pkg::CntPortW-1:0] rsp_removed_reg;
    logic [dqrm_pkg::CntPortW-1:0] rsp_count_reg;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [ID_BITS-1:0]           wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [ID_BITS-1:0]           rd_data;

    logic                         slot_free;
    logic                         full;
    logic                         empty;
    logic                         scan_last;
    logic                         match;
    logic [CW-1:0]                k_inc;
    logic [CW-1:0]                kept_next;
    logic [CW-1:0]                removed_next;
    logic [AW-1:0]                front_dec;
    logic [AW-1:0]                front_inc;
    logic [AW-1:0]                slot_back;
    logic [AW-1:0]                slot_kept;
    logic [AW-1:0]                slot_k1;
    logic [1:0]                   fail_status;

    // (front + offset) mod DEPTH; the sum stays below twice DEPTH
    function automatic logic [AW-1:0] wrap_slot(input logic [AW:0] s);
        if (s >= (AW+1)'(DEPTH))
        begin
            wrap_slot = AW'(s - (AW+1)'(DEPTH));
        end
        else
        begin
            wrap_slot = AW'(s);
        end
    endfunction

    assign slot_free    = !rsp_valid_reg || !rsp_stall;
    assign full         = (count_reg == CW'(DEPTH));
    assign empty        = (count_reg == '0);
    assign k_inc        = k_reg + CW'(1);
    assign scan_last    = (k_inc == count_reg);
    assign match        = (rd_data == id_reg);
    assign kept_next    = match ? kept_reg : kept_reg + CW'(1);
    assign removed_next = match ? removed_reg + CW'(1) : removed_reg;

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = wrap_slot({1'b0, front_reg} + (AW+1)'(1));
    assign slot_back = wrap_slot({1'b0, front_reg} + (AW+1)'(count_reg));
    assign slot_kept = wrap_slot({1'b0, front_reg} + (AW+1)'(kept_reg));
    assign slot_k1   = wrap_slot({1'b0, front_reg} + (AW+1)'(k_inc));

    always_comb
    begin
        case (func_reg)
            dqrm_pkg::FUNC_PUSH_BACK, dqrm_pkg::FUNC_PUSH_FRONT: fail_status = dqrm_pkg::ST_FULL;
            dqrm_pkg::FUNC_POP_FRONT:                            fail_status = dqrm_pkg::ST_EMPTY;
            default:                                             fail_status = dqrm_pkg::ST_OK;
        endcase
    end

    // RAM port control: survivors are written back at the kept offset, never ahead of the read
    always_comb
    begin
        wr_en   = cmd.push || (cmd.scan_step && !match);
        wr_data = cmd.push ? id_reg : rd_data;
        if (cmd.push)
        begin
            wr_addr = (func_reg == dqrm_pkg::FUNC_PUSH_FRONT) ? front_dec : slot_back;
        end
        else
        begin
            wr_addr = slot_kept;
        end
        rd_en   = cmd.pop_rd || cmd.scan_init || (cmd.scan_step && !scan_last);
        rd_addr = cmd.scan_step ? slot_k1 : front_reg;
    end

    dqrm_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                count_reg <= count_reg + CW'(1);
                if (func_reg == dqrm_pkg::FUNC_PUSH_FRONT)
                begin
                    front_reg <= front_dec;
                end
            end
            if (cmd.pop_done)
            begin
                count_reg <= count_reg - CW'(1);
                front_reg <= front_inc;
            end
            if (cmd.scan_step && scan_last)
            begin
                count_reg <= kept_next;
            end

            if (cmd.push || cmd.pop_done || cmd.fail_done || (cmd.scan_step && scan_last))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= dqrm_pkg::func_t'(func);
            id_reg   <= ID_BITS'(tray_id);
        end
        if (cmd.scan_init)
        begin
            k_reg       <= '0;
            kept_reg    <= '0;
            removed_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            k_reg       <= k_inc;
            kept_reg    <= kept_next;
            removed_reg <= removed_next;
        end

        if (cmd.push)
        begin
            rsp_tray_reg    <= '0;
            rsp_status_reg  <= dqrm_pkg::ST_OK;
            rsp_removed_reg <= '0;
            rsp_count_reg   <= dqrm_pkg::CntPortW'(count_reg + CW'(1));
        end
        else if (cmd.pop_done)
        begin
            rsp_tray_reg    <= dqrm_pkg::IdPortW'(rd_data);
            rsp_status_reg  <= dqrm_pkg::ST_OK;
            rsp_removed_reg <= '0;
            rsp_count_reg   <= dqrm_pkg::CntPortW'(count_reg - CW'(1));
        end
        else if (cmd.fail_done)
        begin
            rsp_tray_reg    <= '0;
            rsp_status_reg  <= fail_status;
            rsp_removed_reg <= '0;
            rsp_count_reg   <= dqrm_pkg::CntPortW'(count_reg);
        end
        else if (cmd.scan_step && scan_last)
        begin
            rsp_tray_reg    <= '0;
            rsp_status_reg  <= dqrm_pkg::ST_OK;
            rsp_removed_reg <= dqrm_pkg::CntPortW'(removed_next);
            rsp_count_reg   <= dqrm_pkg::CntPortW'(kept_next);
        end
    end

    assign sts.func      = func_reg;
    assign sts.full      = full;
    assign sts.empty     = empty;
    assign sts.scan_last = scan_last;
    assign sts.slot_free = slot_free;

    assign rsp_valid     = rsp_valid_reg;
    assign tray_out      = rsp_tray_reg;
    assign status        = rsp_status_reg;
    assign removed_count = rsp_removed_reg;
    assign count_after   = rsp_count_reg;

endmodule

/* rtl/deque_with_remove_matching.sv */
// Bounded double-ended queue of tray identifiers with remove-by-value.
// Top level: joins dqrm_ctrl and dqrm_dp; depends on dqrm_pkg, dqrm_ram.
//
// One request at a time: push back, push front, pop front, or remove every
// held entry equal to tray_id while keeping the order of the rest. Every
// request returns exactly one result transfer. Entries live in a DEPTH-entry
// circular RAM with registered read; the front slot and the entry count are
// registers. A push takes the transfer, then writes; a pop reads the RAM and
// returns the registered read data. A remove compacts the held entries by
// walking them through the single RAM read port one per cycle (the last one
// waits for a free result register) and writes each survivor back packed.
// Failed requests (push on full, pop on empty, remove on empty) write nothing.
// The result sits in an output register; a stalled result holds the final
// step of the next request but never the request transfer itself. Counts
// on the result port are the low 5 bits of the internal count.
module deque_with_remove_matching #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  func,
    input  logic [15:0] tray_id,
    // result channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [15:0] tray_out,
    output logic [1:0]  status,
    output logic [4:0]  removed_count,
    output logic [4:0]  count_after
);

    dqrm_pkg::dq_cmd_t cmd;
    dqrm_pkg::dq_sts_t sts;

    // sequence each request: capture, execute, read wait or scan, finish
    dqrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold queue state, the entry RAM and the result register
    dqrm_dp #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (func),
        .tray_id       (tray_id),
        .rsp_stall     (rsp_stall),
        .cmd           (cmd),
        .sts           (sts),
        .rsp_valid     (rsp_valid),
        .tray_out      (tray_out),
        .status        (status),
        .removed_count (removed_count),
        .count_after   (count_after)
    );

    // A full-push result reports a full queue
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == dqrm_pkg::ST_FULL) |-> (count_after == 5'(DEPTH)))
        else $error("full status with count_after not at capacity");

    // An empty-pop result reports zero entries and no identifier
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == dqrm_pkg::ST_EMPTY) |-> (count_after == '0 && tray_out == '0))
        else $error("empty status with nonzero count or identifier");

    // Removed entries only come with an ok status
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && removed_count != '0) |-> (status == dqrm_pkg::ST_OK))
        else $error("removed entries reported with a failure status");

    // The block is busy right after taking a request
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while previous one not started");

endmodule

/* test/tb.sv */
// Self-checking testbench for deque_with_remove_matching.
// Needs dqrm_pkg and the deque_with_remove_matching RTL; an in-bench scoreboard
// predicts every result from the accepted requests.
`timescale 1ns / 100ps

module tb;

    localparam int QDEPTH = 16;

    // Expected contents of one result transfer
    typedef struct packed {
        logic [15:0] tray;
        logic [1:0]  code;
        logic [4:0]  removed;
        logic [4:0]  held;
    } dq_result_t;

    // Shadow deque: replays each accepted request and queues the result it must cause
    class dq_scoreboard;
        logic [15:0] slots [QDEPTH];
        int unsigned head;
        int unsigned held;
        dq_result_t  expected_q [$];
        int          errors;

        function new();
            head   = 0;
            held   = 0;
            errors = 0;
        endfunction

        function void flag(string msg);
            if (errors < 10)
                $display("%s", msg);
            errors++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted request to the shadow state
        function void note_request(dqrm_pkg::func_t f, logic [15:0] id);
            dq_result_t  r;
            int unsigned kept;
            logic [15:0] v;
            r = '0;
            case (f)
                dqrm_pkg::FUNC_PUSH_BACK, dqrm_pkg::FUNC_PUSH_FRONT:
                begin
                    if (held >= QDEPTH)
                    begin
                        r.code = dqrm_pkg::ST_FULL;
                    end
                    else if (f == dqrm_pkg::FUNC_PUSH_BACK)
                    begin
                        slots[(head + held) % QDEPTH] = id;
                        held++;
                    end
                    else
                    begin
                        head = (head + QDEPTH - 1) % QDEPTH;
                        slots[head] = id;
                        held++;
                    end
                end
                dqrm_pkg::FUNC_POP_FRONT:
                begin
                    if (held == 0)
                    begin
                        r.code = dqrm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        r.tray = slots[head];
                        head = (head + 1) % QDEPTH;
                        held--;
                    end
                end
                default:
                begin
                    // Pack survivors in order from the front slot
                    kept = 0;
                    for (int k = 0; k < held; k++)
                    begin
                        v = slots[(head + k) % QDEPTH];
                        if (v == id)
                        begin
                            r.removed++;
                        end
                        else
                        begin
                            slots[(head + kept) % QDEPTH] = v;
                            kept++;
                        end
                    end
                    held = kept;
                end
            endcase
            r.held = 5'(held);
            expected_q.push_back(r);
        endfunction

        // Compare one accepted result against the oldest expectation
        function void check_result(logic [15:0] tray, logic [1:0] code,
                                   logic [4:0] removed, logic [4:0] held_now);
            dq_result_t e;
            string      exp_s;
            string      got_s;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("%0t: result transfer with nothing expected", $realtime));
                return;
            end
            e = expected_q.pop_front();
            if (tray !== e.tray || code !== e.code || removed !== e.removed ||
                held_now !== e.held)
            begin
                exp_s = $sformatf("exp tray %h st %0d rem %0d cnt %0d",
                                  e.tray, e.code, e.removed, e.held);
                got_s = $sformatf("got tray %h st %0d rem %0d cnt %0d",
                                  tray, code, removed, held_now);
                flag($sformatf("%0t: mismatch %s %s", $realtime, exp_s, got_s));
            end
        endfunction

        function void close();
            if (expected_q.size() != 0)
                flag($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        req_valid     = 1'b0;
    logic        req_stall;
    logic [1:0]  func          = dqrm_pkg::FUNC_PUSH_BACK;
    logic [15:0] tray_id       = '0;
    logic        rsp_valid;
    logic        rsp_stall     = 1'b0;
    logic [15:0] tray_out;
    logic [1:0]  status;
    logic [4:0]  removed_count;
    logic [4:0]  count_after;

    dq_scoreboard sb = new();

    // Knobs owned by the main sequence, read by both sides
    bit          no_idle     = 1'b0;
    int          gap_pct     = 25;
    int          holds_asked = 0;
    logic [15:0] id_pool [4];

    deque_with_remove_matching u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .tray_id       (tray_id),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .tray_out      (tray_out),
        .status        (status),
        .removed_count (removed_count),
        .count_after   (count_after)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL deque_with_remove_matching");
        $finish;
    end

    // Offer one request and hold it until the block takes the transfer.
    // An optional idle burst goes in front; valid stays high across
    // back-to-back requests so it is never dropped and raised in one step.
    task automatic send_request(dqrm_pkg::func_t f, logic [15:0] id);
        int gap;
        if (!no_idle && $urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        tray_id   <= id;
        do @(posedge clk); while (req_stall);
        sb.note_request(f, id);
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Draw one random request; most ids come from a small pool so that
    // removals actually hit, the rest cover the full id range
    task automatic random_request(int push_pct, int pop_pct);
        dqrm_pkg::func_t f;
        logic [15:0]     id;
        int              roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            f = $urandom_range(1) ? dqrm_pkg::FUNC_PUSH_FRONT : dqrm_pkg::FUNC_PUSH_BACK;
        else if (roll < push_pct + pop_pct)
            f = dqrm_pkg::FUNC_POP_FRONT;
        else
            f = dqrm_pkg::FUNC_REMOVE;
        if ($urandom_range(99) < 85)
            id = id_pool[$urandom_range(3)];
        else
            id = 16'($urandom_range(16'hFFFF));
        send_request(f, id);
    endtask

    task automatic refresh_pool(int distinct);
        for (int i = 0; i < 4; i++)
            id_pool[i] = (i < distinct) ? 16'($urandom_range(16'hFFFF))
                                        : id_pool[i % distinct];
    endtask

    // Result side: check every accepted transfer, then pick the next stall level.
    // Random stall bursts, occasional long free stretches, and one long
    // hold-off on request so the block backs up into its request port.
    initial
    begin : result_side
        int burst_left;
        int hold_left;
        int holds_served;
        burst_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                sb.check_result(tray_out, status, removed_count, count_after);
            if (hold_left == 0 && holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (no_idle)
            begin
                rsp_stall <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
            end
            else if ($urandom_range(2) == 0)
            begin
                burst_left = $urandom_range(1, 11) - 1;
                rsp_stall <= 1'b1;
            end
            else if ($urandom_range(4) == 0)
            begin
                burst_left = $urandom_range(30, 60);
                rsp_stall <= 1'b0;
            end
            else
            begin
                burst_left = $urandom_range(1, 11) - 1;
                rsp_stall <= 1'b0;
            end
        end
    end

    // Main sequence: reset, directed corner cases, then biased random phases
    initial
    begin : request_side
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: pop reports empty, remove does nothing
        send_request(dqrm_pkg::FUNC_POP_FRONT, 16'h0000);
        send_request(dqrm_pkg::FUNC_REMOVE, 16'hFFFF);
        // Push front wraps the front slot below zero
        send_request(dqrm_pkg::FUNC_PUSH_FRONT, 16'hFFFF);
        send_request(dqrm_pkg::FUNC_PUSH_BACK, 16'h0000);
        // Remove with no match, then a single match at the front
        send_request(dqrm_pkg::FUNC_REMOVE, 16'h1234);
        send_request(dqrm_pkg::FUNC_REMOVE, 16'hFFFF);
        send_request(dqrm_pkg::FUNC_POP_FRONT, 16'hFFFF);
        // Fill to capacity from both ends with interleaved ids
        for (int i = 0; i < QDEPTH; i++)
            send_request(i[0] ? dqrm_pkg::FUNC_PUSH_FRONT : dqrm_pkg::FUNC_PUSH_BACK,
                         (i % 3 == 0) ? 16'h8001 : 16'h5A5A);
        // Full queue refuses pushes at either end
        send_request(dqrm_pkg::FUNC_PUSH_BACK, 16'h7FFF);
        send_request(dqrm_pkg::FUNC_PUSH_FRONT, 16'h8000);
        // Compact out the majority, then remove the rest to empty the queue
        send_request(dqrm_pkg::FUNC_REMOVE, 16'h5A5A);
        send_request(dqrm_pkg::FUNC_REMOVE, 16'h8001);
        drain_results();

        // Phase 0: push-heavy, receiver holds off long at the start
        refresh_pool(4);
        gap_pct = 25;
        holds_asked++;
        for (int i = 0; i < 200; i++)
            random_request(70, 15);
        drain_results();

        // Phase 1: pop-heavy, drives the queue empty often
        refresh_pool(3);
        gap_pct = 40;
        for (int i = 0; i < 200; i++)
            random_request(25, 55);
        drain_results();

        // Phase 2: a pool of two ids, so removals delete many entries
        refresh_pool(2);
        gap_pct = 10;
        for (int i = 0; i < 200; i++)
            random_request(40, 30);
        drain_results();

        // Phase 3: remove-heavy while filling up
        refresh_pool(4);
        gap_pct = 30;
        for (int i = 0; i < 200; i++)
            random_request(55, 10);
        drain_results();

        // Phase 4: full rate on both sides
        refresh_pool(3);
        no_idle = 1'b1;
        for (int i = 0; i < 200; i++)
            random_request(45, 30);
        drain_results();

        // Keep clocking after the drain to catch stray transfers
        repeat (40) @(posedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("PASS deque_with_remove_matching");
        else
            $display("FAIL deque_with_remove_matching");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dqrm_pkg.sv
rtl/dqrm_ram.sv
rtl/dqrm_ctrl.sv
rtl/dqrm_dp.sv
rtl/deque_with_remove_matching.sv
test/tb.sv
